FILE: src/mep_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mep_pkg: shared types and constants for the escape-time pixel block
// Fixed-point format, register map, FSM states, glyph table and saturation.
// ---------------------------------------------------------------------------
package mep_pkg;

  localparam int COORD_W     = 12;   // column / row port width
  localparam int Q_W         = 32;   // signed Q4.28 word
  localparam int STEP_W      = 31;   // unsigned step registers
  localparam int FRAC_BITS   = 28;
  localparam int PROD_W      = 64;   // full 32x32 product
  localparam int ITER_W      = 7;    // iterations / glyph field width
  localparam int CFG_IDX_W   = 2;

  localparam int MAX_ITER_DEF   = 75;
  localparam int COORD_BITS_DEF = 12;

  localparam logic [Q_W-1:0]    REAL_ORIGIN_RST = 32'hE000_0000;  // -2.0
  localparam logic [STEP_W-1:0] REAL_STEP_RST   = 31'd894785;
  localparam logic [Q_W-1:0]    IMAG_ORIGIN_RST = 32'hE666_6666;  // about -1.6
  localparam logic [STEP_W-1:0] IMAG_STEP_RST   = 31'd2454267;

  // 4.0 in Q8.56
  localparam logic [PROD_W:0] FOUR_Q = 65'd1 << (2 * FRAC_BITS + 2);

  localparam logic signed [65:0] Q_MAX_W = 66'sd2147483647;
  localparam logic signed [65:0] Q_MIN_W = -66'sd2147483648;

  localparam logic [ITER_W-1:0] ITER_CAP    = 7'd127;
  localparam logic [ITER_W-1:0] GLYPH_SPACE = 7'h20;
  localparam logic [ITER_W-1:0] GLYPH_HASH  = 7'h23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REAL_ORIGIN,
    REG_REAL_STEP,
    REG_IMAG_ORIGIN,
    REG_IMAG_STEP
  } mep_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_ADD,
    S_SQUARE,
    S_STEP,
    S_EMIT
  } mep_state_t;

  typedef struct packed {
    logic [Q_W-1:0]    real_origin;
    logic [STEP_W-1:0] real_step;
    logic [Q_W-1:0]    imag_origin;
    logic [STEP_W-1:0] imag_step;
  } mep_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } mep_pix_t;

  typedef struct packed {
    logic [ITER_W-1:0] iterations;
    logic              escaped;
    logic [ITER_W-1:0] glyph;
  } mep_res_t;

  // operand pairs for the three multiplier lanes
  typedef struct packed {
    logic [Q_W-1:0] a0;
    logic [Q_W-1:0] b0;
    logic [Q_W-1:0] a1;
    logic [Q_W-1:0] b1;
    logic [Q_W-1:0] a2;
    logic [Q_W-1:0] b2;
  } mep_mul_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] p0;
    logic [PROD_W-1:0] p1;
    logic [PROD_W-1:0] p2;
  } mep_mul_rsp_t;

  function automatic logic [Q_W-1:0] mep_sat_q(input logic signed [65:0] v);
    logic [Q_W-1:0] r;
    if (v > Q_MAX_W) begin
      r = 32'h7FFF_FFFF;
    end else if (v < Q_MIN_W) begin
      r = 32'h8000_0000;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // density ramp " .:+*#@"
  function automatic logic [ITER_W-1:0] mep_shade(input logic [2:0] idx);
    logic [ITER_W-1:0] g;
    unique case (idx)
      3'd0:    g = 7'h20;
      3'd1:    g = 7'h2E;
      3'd2:    g = 7'h3A;
      3'd3:    g = 7'h2B;
      3'd4:    g = 7'h2A;
      3'd5:    g = 7'h23;
      3'd6:    g = 7'h40;
      default: g = 7'h20;
    endcase
    return g;
  endfunction

endpackage

FILE: src/mep_intf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mep_intf: valid/ready channel interfaces
// Pixel request channel and escape-time result channel.
// ---------------------------------------------------------------------------
interface mep_pixel_if;
  import mep_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

interface mep_result_if;
  import mep_pkg::*;
  logic              valid;
  logic              ready;
  logic [ITER_W-1:0] iterations;
  logic              escaped;
  logic [ITER_W-1:0] glyph;
  modport source (output valid, output iterations, output escaped, output glyph,
                  input ready);
  modport sink   (input valid, input iterations, input escaped, input glyph,
                  output ready);
endinterface

FILE: src/mandelbrot_escape_time_pixel_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top: escape-time iteration for one pixel
// Config registers, shared multiplier and the per-pixel sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   pixel  : valid/ready sink, one beat = column and row of a pixel. Only the
//            low COORD_BITS bits of each are used.
//   result : valid/ready source, one beat per pixel = iteration count,
//            escaped flag and ASCII density glyph.
//   cfg_*  : write port for real_origin (0), real_step (1), imag_origin (2)
//            and imag_step (3); write only while no pixel is in flight.
// Sequencing: one pixel at a time. The three-lane multiplier is shared between
//   mapping and squaring, and each iteration is a square state (S_SQUARE)
//   followed by an add/compare state (S_STEP). The sequencer returns to idle
//   as the result is registered, and only then takes the next pixel.
// Reset (rst, synchronous): sequencer idle, result channel empty, config
//   registers back to the default view.
// Stall: the result sits in an output register; a finished pixel waits in
//   the sequencer until that register frees, and no new pixel is taken.
// ---------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_top #(
  parameter int MAX_ITER   = mep_pkg::MAX_ITER_DEF,
  parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mep_pkg::Q_W-1:0]           cfg_data,
  mep_pixel_if.sink                         pixel,
  mep_result_if.source                      result
);
  import mep_pkg::*;

  mep_cfg_t     cfg;
  mep_pix_t     pix;
  mep_res_t     res;
  mep_mul_req_t mul_req;
  mep_mul_rsp_t mul_rsp;

  // configuration registers; unused index codes do not exist at this width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.real_origin <= REAL_ORIGIN_RST;
      cfg.real_step   <= REAL_STEP_RST;
      cfg.imag_origin <= IMAG_ORIGIN_RST;
      cfg.imag_step   <= IMAG_STEP_RST;
    end else if (cfg_we) begin
      unique case (mep_reg_t'(cfg_index))
        REG_REAL_ORIGIN: cfg.real_origin <= cfg_data;
        REG_REAL_STEP:   cfg.real_step   <= cfg_data[STEP_W-1:0];
        REG_IMAG_ORIGIN: cfg.imag_origin <= cfg_data;
        REG_IMAG_STEP:   cfg.imag_step   <= cfg_data[STEP_W-1:0];
        default:         ;
      endcase
    end
  end

  assign pix.column = pixel.column;
  assign pix.row    = pixel.row;

  mep_mul3 u_mul (
    .clk (clk),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  mep_iter #(
    .MAX_ITER   (MAX_ITER),
    .COORD_BITS (COORD_BITS)
  ) u_iter (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .pix       (pix),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .res       (res)
  );

  assign result.iterations = res.iterations;
  assign result.escaped    = res.escaped;
  assign result.glyph      = res.glyph;

endmodule

FILE: src/mep_mul3.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mep_mul3: shared three-lane signed multiplier
// Three 32x32 signed products, registered; used for mapping and squaring.
// ---------------------------------------------------------------------------
module mep_mul3 (
  input  logic                  clk,
  input  mep_pkg::mep_mul_req_t req,
  output mep_pkg::mep_mul_rsp_t rsp
);
  import mep_pkg::*;

  always_ff @(posedge clk) begin
    rsp.p0 <= $signed(req.a0) * $signed(req.b0);
    rsp.p1 <= $signed(req.a1) * $signed(req.b1);
    rsp.p2 <= $signed(req.a2) * $signed(req.b2);
  end

endmodule

FILE: src/mep_iter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mep_iter: pixel sequencer and escape-time datapath
// Maps the pixel to c, runs z = z*z + c on the shared multiplier, picks glyph.
// ---------------------------------------------------------------------------
module mep_iter #(
  parameter int MAX_ITER   = mep_pkg::MAX_ITER_DEF,
  parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mep_pkg::mep_cfg_t     cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mep_pkg::mep_pix_t     pix,
  output mep_pkg::mep_mul_req_t mul_req,
  input  mep_pkg::mep_mul_rsp_t mul_rsp,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mep_pkg::mep_res_t     res
);
  import mep_pkg::*;

  localparam int CNT_W     = $clog2(MAX_ITER + 1);
  localparam int EXT_W     = 11;
  localparam int USE_BITS  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int GLYPH_DIV = MAX_ITER - 21;
  localparam logic [EXT_W-1:0] LATE_LIM = EXT_W'(MAX_ITER - 20);
  localparam logic [CNT_W-1:0] LAST_N   = CNT_W'(MAX_ITER - 1);
  // n >= THR[k]  <=>  floor(6n / GLYPH_DIV) >= k
  localparam logic [EXT_W-1:0] THR [1:6] = '{
    EXT_W'((1 * GLYPH_DIV + 5) / 6),
    EXT_W'((2 * GLYPH_DIV + 5) / 6),
    EXT_W'((3 * GLYPH_DIV + 5) / 6),
    EXT_W'((4 * GLYPH_DIV + 5) / 6),
    EXT_W'((5 * GLYPH_DIV + 5) / 6),
    EXT_W'((6 * GLYPH_DIV + 5) / 6)
  };

  mep_state_t state, state_next;

  logic [COORD_W-1:0] col_q, row_q;
  logic [Q_W-1:0]     cr, ci, zr, zi;
  logic [CNT_W-1:0]   n;
  logic               esc;
  logic               out_load;

  logic signed [45:0] cr_sum, ci_sum;
  logic signed [64:0] re_diff, re_sh, im_dbl, im_sh;
  logic signed [65:0] re_sum, im_sum;
  logic [PROD_W:0]    mag;
  logic               escape;
  logic [Q_W-1:0]     zr_next, zi_next;

  logic [EXT_W-1:0]   n_ext;
  logic [2:0]         shade_v;
  logic [ITER_W-1:0]  glyph_sel, iters_sel;

  // ---- next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_MAP_MUL;
      S_MAP_MUL: state_next = S_MAP_ADD;
      S_MAP_ADD: state_next = S_SQUARE;
      S_SQUARE:  state_next = S_STEP;
      S_STEP: begin
        if (escape || n == LAST_N) state_next = S_EMIT;
        else                       state_next = S_SQUARE;
      end
      S_EMIT:    if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // ---- control outputs and multiplier operand select
  always_comb begin
    in_ready = (state == S_IDLE);
    out_load = (state == S_EMIT) && (!out_valid || out_ready);
    if (state == S_MAP_MUL) begin
      mul_req.a0 = Q_W'(col_q);
      mul_req.b0 = {1'b0, cfg.real_step};
      mul_req.a1 = Q_W'(row_q);
      mul_req.b1 = {1'b0, cfg.imag_step};
      mul_req.a2 = '0;
      mul_req.b2 = '0;
    end else begin
      mul_req.a0 = zr;
      mul_req.b0 = zr;
      mul_req.a1 = zi;
      mul_req.b1 = zi;
      mul_req.a2 = zr;
      mul_req.b2 = zi;
    end
  end

  // ---- datapath
  always_comb begin
    // c = origin + coord * step (products are below 2^43)
    cr_sum = $signed({{14{cfg.real_origin[Q_W-1]}}, cfg.real_origin})
           + $signed({2'b00, mul_rsp.p0[43:0]});
    ci_sum = $signed({{14{cfg.imag_origin[Q_W-1]}}, cfg.imag_origin})
           + $signed({2'b00, mul_rsp.p1[43:0]});

    // zr*zr and zi*zi are non-negative squares
    mag    = {1'b0, mul_rsp.p0} + {1'b0, mul_rsp.p1};
    escape = (mag >= FOUR_Q);

    re_diff = $signed({mul_rsp.p0[PROD_W-1], mul_rsp.p0})
            - $signed({mul_rsp.p1[PROD_W-1], mul_rsp.p1});
    re_sh   = re_diff >>> FRAC_BITS;
    re_sum  = $signed({re_sh[64], re_sh}) + $signed({{34{cr[Q_W-1]}}, cr});
    zr_next = mep_sat_q(re_sum);

    im_dbl  = $signed({mul_rsp.p2, 1'b0});
    im_sh   = im_dbl >>> FRAC_BITS;
    im_sum  = $signed({im_sh[64], im_sh}) + $signed({{34{ci[Q_W-1]}}, ci});
    zi_next = mep_sat_q(im_sum);
  end

  // ---- glyph and count for the finished pixel
  always_comb begin
    n_ext   = {{(EXT_W - CNT_W){1'b0}}, n};
    shade_v = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (n_ext >= THR[k]) shade_v = shade_v + 3'd1;
    end
    priority if (!esc) begin
      glyph_sel = GLYPH_SPACE;
    end else if (n_ext > LATE_LIM) begin
      glyph_sel = GLYPH_HASH;
    end else begin
      glyph_sel = mep_shade(3'd6 - shade_v);
    end
    iters_sel = (n_ext > EXT_W'(ITER_CAP)) ? ITER_CAP : n_ext[ITER_W-1:0];
  end

  // ---- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // ---- payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      col_q <= COORD_W'(pix.column[USE_BITS-1:0]);
      row_q <= COORD_W'(pix.row[USE_BITS-1:0]);
    end
    if (state == S_MAP_ADD) begin
      cr  <= mep_sat_q(66'(cr_sum));
      ci  <= mep_sat_q(66'(ci_sum));
      zr  <= '0;
      zi  <= '0;
      n   <= '0;
      esc <= 1'b0;
    end
    if (state == S_STEP) begin
      if (escape) begin
        esc <= 1'b1;
      end else begin
        zr <= zr_next;
        zi <= zi_next;
        n  <= n + CNT_W'(1);
      end
    end
    if (out_load) begin
      res.iterations <= iters_sel;
      res.escaped    <= esc;
      res.glyph      <= glyph_sel;
    end
  end

`ifndef SYNTHESIS
  a_step_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (n < CNT_W'(MAX_ITER)))
    else $error("iteration count ran past the limit");

  a_esc_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && esc) |-> (n < CNT_W'(MAX_ITER)))
    else $error("escaped pixel reports a full count");

  a_noesc_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !esc) |-> (n == CNT_W'(MAX_ITER)))
    else $error("bounded pixel finished early");

  a_accept_map: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MAP_MUL && !in_ready))
    else $error("accepted pixel did not start mapping");
`endif

endmodule
